### hdl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasteriser.
// Used by every module of the block; depends on nothing.
package mlr_pkg;

   // Coordinate width, the width of the midpoint decision terms and the command queue depth
   localparam int COORD_BITS      = 12;
   localparam int DEC_BITS        = COORD_BITS + 3;
   localparam int CMD_QUEUE_DEPTH = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] ucoord_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // Octants, counted anticlockwise from the shallow +x/+y one
   typedef enum logic [2:0] {
      OCT_0 = 3'd0,
      OCT_1 = 3'd1,
      OCT_2 = 3'd2,
      OCT_3 = 3'd3,
      OCT_4 = 3'd4,
      OCT_5 = 3'd5,
      OCT_6 = 3'd6,
      OCT_7 = 3'd7
   } octant_type;

   typedef struct packed {
      op_type    opcode;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_type;

   // Classified command passed from front to back
   typedef struct packed {
      op_type     opcode;
      octant_type octant;
      ucoord_type major_start;
      ucoord_type minor_start;
      ucoord_type major_len;
      ucoord_type minor_len;
   } cmd_type;

endpackage

### hdl/mlr_front.sv
// Front end: classifies each incoming item and folds a load into octant 0.
// Depends on mlr_pkg.
module mlr_front
   import mlr_pkg::*;
(
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic        [COORD_BITS:0] adx_w;
   logic        [COORD_BITS:0] ady_w;
   ucoord_type                 adx;
   ucoord_type                 ady;
   ucoord_type                 x0;
   ucoord_type                 y0;
   ucoord_type                 nx0;
   ucoord_type                 ny0;
   logic                       x_fwd;
   logic                       y_fwd;
   logic                       x_gt;

   // Handshake towards the queue
   assign full     = queue_full;
   assign cmd_push = push && !queue_full;

   // Deltas and their magnitudes; a magnitude always fits the coordinate width
   always_comb begin
      dx    = (COORD_BITS+1)'(req_data.end_x) - (COORD_BITS+1)'(req_data.start_x);
      dy    = (COORD_BITS+1)'(req_data.end_y) - (COORD_BITS+1)'(req_data.start_y);
      adx_w = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
      ady_w = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
      adx   = adx_w[COORD_BITS-1:0];
      ady   = ady_w[COORD_BITS-1:0];
      x0    = ucoord_type'(req_data.start_x);
      y0    = ucoord_type'(req_data.start_y);
      nx0   = ucoord_type'(0) - x0;
      ny0   = ucoord_type'(0) - y0;
      x_fwd = req_data.end_x >= req_data.start_x;
      y_fwd = req_data.end_y >= req_data.start_y;
      x_gt  = req_data.end_x > req_data.start_x;
   end

   // Octant choice and mirroring of the start point
   always_comb begin
      cmd.opcode = req_data.opcode;
      if (adx >= ady) begin
         cmd.major_len = adx;
         cmd.minor_len = ady;
         priority if (x_fwd && y_fwd) begin
            cmd.octant = OCT_0; cmd.major_start = x0;  cmd.minor_start = y0;
         end else if (x_fwd) begin
            cmd.octant = OCT_7; cmd.major_start = x0;  cmd.minor_start = ny0;
         end else if (y_fwd) begin
            cmd.octant = OCT_3; cmd.major_start = nx0; cmd.minor_start = y0;
         end else begin
            cmd.octant = OCT_4; cmd.major_start = nx0; cmd.minor_start = ny0;
         end
      end else begin
         cmd.major_len = ady;
         cmd.minor_len = adx;
         priority if (y_fwd && x_fwd) begin
            cmd.octant = OCT_1; cmd.major_start = y0;  cmd.minor_start = x0;
         end else if (y_fwd) begin
            cmd.octant = OCT_2; cmd.major_start = y0;  cmd.minor_start = nx0;
         end else if (x_gt) begin
            cmd.octant = OCT_6; cmd.major_start = ny0; cmd.minor_start = x0;
         end else begin
            cmd.octant = OCT_5; cmd.major_start = ny0; cmd.minor_start = nx0;
         end
      end
   end

endmodule

### hdl/mlr_cmd_queue.sv
// Short command queue between the front and back ends.
// Depends on mlr_pkg.
module mlr_cmd_queue
   import mlr_pkg::*;
#(
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   output logic    rd_valid,
   input  logic    rd_en,
   output cmd_type rd_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type               slots_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff,  count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full     = count_ff == CNT_BITS'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = slots_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hdl/mlr_back.sv
// Back end: walks the midpoint decision in octant 0 and maps pixels back.
// Holds the line state and the result register. Depends on mlr_pkg.
module mlr_back
   import mlr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   octant_type  octant_ff,        octant_in;
   ucoord_type  walk_major_ff,    walk_major_in;
   ucoord_type  walk_minor_ff,    walk_minor_in;
   ucoord_type  major_limit_ff,   major_limit_in;
   dec_type     decision_ff,      decision_in;
   dec_type     step_east_ff,     step_east_in;
   dec_type     step_diagonal_ff, step_diagonal_in;
   logic        line_active_ff,   line_active_in;
   logic        out_valid_ff,     out_valid_in;
   rsp_type     out_data_ff,      out_data_in;

   logic        is_step;
   logic        out_free;
   logic        emit;
   logic        do_load;
   dec_type     minor2;
   dec_type     len2;
   dec_type     len1;
   ucoord_type  px;
   ucoord_type  py;
   ucoord_type  neg_major;
   ucoord_type  neg_minor;

   // Transfer control: loads and idle steps never wait on the result side
   assign is_step  = cmd.opcode == OP_STEP;
   assign out_free = !out_valid_ff || pop;
   assign emit     = cmd_valid && is_step && line_active_ff && out_free;
   assign do_load  = cmd_valid && !is_step;
   assign cmd_pop  = cmd_valid && (!is_step || !line_active_ff || out_free);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_data_ff;

   // Decision terms for a new line
   assign minor2 = dec_type'({cmd.minor_len, 1'b0});
   assign len2   = dec_type'({cmd.major_len, 1'b0});
   assign len1   = dec_type'(cmd.major_len);

   // Map the current point back out of octant 0
   assign neg_major = ucoord_type'(0) - walk_major_ff;
   assign neg_minor = ucoord_type'(0) - walk_minor_ff;

   always_comb begin
      unique case (octant_ff)
         OCT_0:   begin px = walk_major_ff; py = walk_minor_ff; end
         OCT_1:   begin px = walk_minor_ff; py = walk_major_ff; end
         OCT_2:   begin px = neg_minor;     py = walk_major_ff; end
         OCT_3:   begin px = neg_major;     py = walk_minor_ff; end
         OCT_4:   begin px = neg_major;     py = neg_minor;     end
         OCT_5:   begin px = neg_minor;     py = neg_major;     end
         OCT_6:   begin px = walk_minor_ff; py = neg_major;     end
         default: begin px = walk_major_ff; py = neg_minor;     end
      endcase
   end

   // Line state update; a load and a pixel step never coincide
   always_comb begin
      octant_in        = octant_ff;
      walk_major_in    = walk_major_ff;
      walk_minor_in    = walk_minor_ff;
      major_limit_in   = major_limit_ff;
      decision_in      = decision_ff;
      step_east_in     = step_east_ff;
      step_diagonal_in = step_diagonal_ff;
      line_active_in   = line_active_ff;
      if (do_load) begin
         octant_in        = cmd.octant;
         walk_major_in    = cmd.major_start;
         walk_minor_in    = cmd.minor_start;
         major_limit_in   = cmd.major_len;
         decision_in      = minor2 - len1;
         step_east_in     = minor2;
         step_diagonal_in = minor2 - len2;
         line_active_in   = 1'b1;
      end else if (emit) begin
         if (major_limit_ff == '0) begin
            line_active_in = 1'b0;
         end else begin
            if (decision_ff[DEC_BITS-1]) begin
               decision_in = decision_ff + step_east_ff;
            end else begin
               decision_in   = decision_ff + step_diagonal_ff;
               walk_minor_in = walk_minor_ff + 1'b1;
            end
            walk_major_in  = walk_major_ff + 1'b1;
            major_limit_in = major_limit_ff - 1'b1;
         end
      end
   end

   // Result register
   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_data_in.pixel_x    = coord_type'(px);
         out_data_in.pixel_y    = coord_type'(py);
         out_data_in.last_pixel = major_limit_ff == '0;
         out_valid_in           = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octant_ff        <= OCT_0;
         walk_major_ff    <= '0;
         walk_minor_ff    <= '0;
         major_limit_ff   <= '0;
         decision_ff      <= '0;
         step_east_ff     <= '0;
         step_diagonal_ff <= '0;
         line_active_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         octant_ff        <= octant_in;
         walk_major_ff    <= walk_major_in;
         walk_minor_ff    <= walk_minor_in;
         major_limit_ff   <= major_limit_in;
         decision_ff      <= decision_in;
         step_east_ff     <= step_east_in;
         step_diagonal_ff <= step_diagonal_in;
         line_active_ff   <= line_active_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

endmodule

### hdl/midpoint_line_rasterizer_top.sv
// Midpoint line rasteriser, eight octants, endpoint inclusive.
// Items enter as a queue: push/full with req_data. A load item (opcode 0)
// latches two endpoints and gives no pixel; a step item (opcode 1) gives the
// next pixel of the active line, last_pixel marking the end point. Steps
// with no active line are dropped.
// Results leave as a queue: empty/pop with rsp_data, oldest first.
// A step is classified combinationally into the command queue; the walker then
// registers its pixel in the result register.
// Throughput: one item per cycle while the result register is free or popped;
// the walker updates its decision term on each pixel step. Loads and idle steps never wait for the result side.
// When pop is held low the result register holds its pixel, the walker stops
// at the next active step, the two-entry command queue fills and full rises.
// Synchronous reset empties the queue and result register and leaves no line
// active. Depends on mlr_pkg, mlr_front, mlr_cmd_queue and mlr_back.
module midpoint_line_rasterizer_top
   import mlr_pkg::*;
#(
   parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_out;

   // Classification
   mlr_front u_front (
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in)
   );

   // Decoupling queue
   mlr_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_push),
      .wr_data  (cmd_in),
      .full     (queue_full),
      .rd_valid (cmd_valid),
      .rd_en    (cmd_pop),
      .rd_data  (cmd_out)
   );

   // Line walker
   mlr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb_midpoint_line_rasterizer_top.sv
// Self-checking testbench for the midpoint line rasteriser top level.
// A directed table, then random lines; pixels are checked against the table or an in-bench line tracer.
// Depends on mlr_pkg and midpoint_line_rasterizer_top.
module tb_midpoint_line_rasterizer_top;
   import mlr_pkg::*;

   localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
   localparam int PHASE_ITEMS   = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 8;
   localparam int DIRECTED_ROWS = 25;

   // How a directed row's pixel is obtained
   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_PIXEL,
      EXP_NONE
   } exp_kind_type;

   typedef struct {
      op_type       op;
      int           sx;
      int           sy;
      int           ex;
      int           ey;
      exp_kind_type kind;
      int           px;
      int           py;
      bit           last;
   } vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Tracer state, kept in octant-0 space
   octant_type trace_oct = OCT_0;
   ucoord_type major_pos = '0;
   ucoord_type minor_pos = '0;
   ucoord_type steps_left = '0;
   dec_type    err_term = '0;
   dec_type    err_inc_e = '0;
   dec_type    err_inc_ne = '0;
   bit         tracing = 1'b0;

   rsp_type    pixel_q[$];
   int         gap_pct = 19;
   int         stall_pct = 52;
   int         error_count = 0;
   int         useful_items = 0;
   int         pixels_checked = 0;
   int         lines_loaded = 0;
   int         quiet_cycles = 0;
   logic [7:0] octants_seen = '0;

   vector_type directed_rows [DIRECTED_ROWS] = '{
      // step with no line active, then single-pixel lines at both corners
      '{OP_STEP, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, EXP_NONE, 0, 0, 1'b0},
      '{OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, COORD_MIN, COORD_MIN, 1'b1},
      '{OP_STEP, 0, 0, 0, 0, EXP_NONE, 0, 0, 1'b0},
      '{OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, COORD_MAX, COORD_MAX, 1'b1},
      // full-width horizontal line, dropped by the next load
      '{OP_LOAD, COORD_MIN, 0, COORD_MAX, 0, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, COORD_MIN, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      // corner-to-corner diagonal, loaded while a line is active
      '{OP_LOAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, COORD_MAX, COORD_MIN, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      // steep line walked to its end point
      '{OP_LOAD, 0, 0, 1, 3, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_PIXEL, 1, 3, 1'b1},
      // shallow line down-left
      '{OP_LOAD, 0, 0, -2, -1, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      // vertical line downwards
      '{OP_LOAD, 5, 5, 5, 3, EXP_NONE, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, EXP_MODEL, 0, 0, 1'b0}
   };

   midpoint_line_rasterizer_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Line tracer: a load sets up the octant walk, a step gives the next pixel
   function automatic void trace_item(input req_type item, output bit has_pixel,
                                      output rsp_type pixel);
      int x0, y0, x1, y1, adx, ady, a0, b0, len, minor;
      ucoord_type px, py;
      has_pixel = 1'b0;
      pixel = '0;
      if (item.opcode == OP_LOAD) begin
         x0 = item.start_x;
         y0 = item.start_y;
         x1 = item.end_x;
         y1 = item.end_y;
         adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
         ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
         if (adx >= ady) begin
            if (x1 >= x0 && y1 >= y0) begin
               trace_oct = OCT_0; a0 = x0; b0 = y0;
            end else if (x1 >= x0) begin
               trace_oct = OCT_7; a0 = x0; b0 = -y0;
            end else if (y1 >= y0) begin
               trace_oct = OCT_3; a0 = -x0; b0 = y0;
            end else begin
               trace_oct = OCT_4; a0 = -x0; b0 = -y0;
            end
            len = adx;
            minor = ady;
         end else begin
            if (y1 >= y0 && x1 >= x0) begin
               trace_oct = OCT_1; a0 = y0; b0 = x0;
            end else if (y1 >= y0) begin
               trace_oct = OCT_2; a0 = y0; b0 = -x0;
            end else if (x1 > x0) begin
               trace_oct = OCT_6; a0 = -y0; b0 = x0;
            end else begin
               trace_oct = OCT_5; a0 = -y0; b0 = -x0;
            end
            len = ady;
            minor = adx;
         end
         major_pos = a0[COORD_BITS-1:0];
         minor_pos = b0[COORD_BITS-1:0];
         steps_left = len[COORD_BITS-1:0];
         err_term = dec_type'(2 * minor - len);
         err_inc_e = dec_type'(2 * minor);
         err_inc_ne = dec_type'(2 * (minor - len));
         tracing = 1'b1;
         octants_seen[trace_oct] = 1'b1;
         lines_loaded++;
      end else if (tracing) begin
         // map the octant-0 point back; mirroring is a two's complement negation
         case (trace_oct)
            OCT_0: begin px = major_pos; py = minor_pos; end
            OCT_1: begin px = minor_pos; py = major_pos; end
            OCT_2: begin px = -minor_pos; py = major_pos; end
            OCT_3: begin px = -major_pos; py = minor_pos; end
            OCT_4: begin px = -major_pos; py = -minor_pos; end
            OCT_5: begin px = -minor_pos; py = -major_pos; end
            OCT_6: begin px = minor_pos; py = -major_pos; end
            default: begin px = major_pos; py = -minor_pos; end
         endcase
         has_pixel = 1'b1;
         pixel.pixel_x = px;
         pixel.pixel_y = py;
         if (steps_left == '0) begin
            pixel.last_pixel = 1'b1;
            tracing = 1'b0;
         end else begin
            if (err_term < 0) begin
               err_term = err_term + err_inc_e;
            end else begin
               err_term = err_term + err_inc_ne;
               minor_pos = minor_pos + 1'b1;
            end
            major_pos = major_pos + 1'b1;
            steps_left = steps_left - 1'b1;
         end
      end
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // One input transfer, with random sender gaps; the pixel is predicted on acceptance
   task automatic send_item(input req_type item, input exp_kind_type kind,
                            input rsp_type typed);
      bit has_pixel;
      rsp_type pixel;
      while ($urandom_range(0, 99) < gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      trace_item(item, has_pixel, pixel);
      case (kind)
         EXP_MODEL: if (has_pixel) pixel_q.push_back(pixel);
         EXP_PIXEL: pixel_q.push_back(typed);
         default: ;
      endcase
      if (item.opcode == OP_LOAD || has_pixel)
         useful_items++;
   endtask

   // A random line: mostly walked to its end, sometimes cut short or overrun
   task automatic send_random_line();
      int x0, y0, x1, y1, span, len, steps, pick;
      req_type item;
      logic [63:0] noise;
      pick = $urandom_range(0, 99);
      span = (pick < 85) ? 12 : 48;
      x0 = int'($urandom_range(0, 4095)) - 2048;
      y0 = int'($urandom_range(0, 4095)) - 2048;
      if ($urandom_range(0, 9) == 0)
         x0 = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
      if ($urandom_range(0, 9) == 0)
         y0 = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
      if (pick >= 97) begin
         x1 = int'($urandom_range(0, 4095)) - 2048;
         y1 = int'($urandom_range(0, 4095)) - 2048;
      end else begin
         x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
         y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
      end
      len = (x1 > x0) ? x1 - x0 : x0 - x1;
      if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
         len = (y1 > y0) ? y1 - y0 : y0 - y1;
      pick = $urandom_range(0, 99);
      if (len > 64)
         steps = $urandom_range(1, 24);
      else if (pick < 75)
         steps = len + 1;
      else if (pick < 88)
         steps = $urandom_range(0, len);
      else
         steps = len + 1 + $urandom_range(1, 3);
      item.opcode = OP_LOAD;
      item.start_x = x0[COORD_BITS-1:0];
      item.start_y = y0[COORD_BITS-1:0];
      item.end_x = x1[COORD_BITS-1:0];
      item.end_y = y1[COORD_BITS-1:0];
      send_item(item, EXP_MODEL, '0);
      repeat (steps) begin
         // coordinates of a step are ignored, so they carry noise
         noise = {$urandom, $urandom};
         item = noise[$bits(req_type)-1:0];
         item.opcode = OP_STEP;
         send_item(item, EXP_MODEL, '0);
      end
   endtask

   // Always waits on the clock before it checks, so push is never driven twice in one step
   task automatic wait_drained();
      do @(posedge clock); while (pixel_q.size() != 0);
   endtask

   // Receiver: pop stalls at random
   always @(posedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Result check and watchdog
   always @(posedge clock) begin : check_pixels
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected pixel: pixel_x %0d pixel_y %0d last_pixel %0d",
                   rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.last_pixel);
            error_count++;
         end else begin
            want = pixel_q.pop_front();
            pixels_checked++;
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
               error_count++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
               error_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0d, got %0d", want.last_pixel,
                      rsp_data.last_pixel);
               error_count++;
            end
         end
      end
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      vector_type row;
      req_type item;
      rsp_type typed;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         item.opcode = row.op;
         item.start_x = row.sx[COORD_BITS-1:0];
         item.start_y = row.sy[COORD_BITS-1:0];
         item.end_x = row.ex[COORD_BITS-1:0];
         item.end_y = row.ey[COORD_BITS-1:0];
         typed.pixel_x = row.px[COORD_BITS-1:0];
         typed.pixel_y = row.py[COORD_BITS-1:0];
         typed.last_pixel = row.last;
         send_item(item, row.kind, typed);
      end

      // random lines in three phases, the last without gaps or stalls, draining after each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin gap_pct = 19; stall_pct = 52; end
            1: begin gap_pct = 52; stall_pct = 19; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         target = useful_items + PHASE_ITEMS;
         while (useful_items < target)
            send_random_line();
         push <= 1'b0;
         wait_drained();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d loads and pixel steps transferred, %0d pixels checked, %0d lines",
               useful_items, pixels_checked, lines_loaded);
      $display("octants loaded (bit per octant): %b", octants_seen);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
